@@ hw/rtl/lidar_spherical_to_cartesian_filter_top_macros.svh @@
// assertion helpers for the point converter
`ifndef LIDAR_SPHERICAL_TO_CARTESIAN_FILTER_TOP_MACROS_SVH
`define LIDAR_SPHERICAL_TO_CARTESIAN_FILTER_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define LSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/lsc_pkg.sv @@
package lsc_pkg;
    localparam int CORDIC_STEPS = 24;
    localparam int ZW           = 32;
    localparam int CW           = 33;
    localparam int MAX_POINTS   = 32768;
    localparam int RANGE_BITS   = 18;
    localparam int ANGLE_BITS   = 16;
    localparam logic signed [CW-1:0] CORDIC_K = 33'sd652032874;

    localparam logic [1:0] REG_TILT  = 2'd0;
    localparam logic [1:0] REG_FWD   = 2'd1;
    localparam logic [1:0] REG_ZERO  = 2'd2;

    function automatic logic [ZW-1:0] atan_entry(input logic [4:0] i);
        logic [ZW-1:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    typedef struct packed {
        logic signed [17:0] c;
        logic signed [17:0] s;
    } sincos_t;
endpackage

@@ hw/rtl/lsc_cordic.sv @@
// one cordic step per cycle, first quadrant, quadrant fix-up after
module lsc_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          phase,
    output logic                 done,
    output lsc_pkg::sincos_t     result
);
    logic signed [lsc_pkg::CW-1:0] x_reg, y_reg;
    logic signed [lsc_pkg::ZW:0]   z_reg;
    logic [4:0]                    step_reg;
    logic                          busy_reg;
    logic [1:0]                    quad_reg;
    logic signed [lsc_pkg::CW-1:0] dx, dy, xr, yr;
    logic signed [lsc_pkg::ZW:0]   at;
    logic signed [17:0]            cv, sv;

    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign at = {1'b0, lsc_pkg::atan_entry(step_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                x_reg    <= lsc_pkg::CORDIC_K;
                y_reg    <= '0;
                z_reg    <= {3'b0, phase[29:0]};
                quad_reg <= phase[31:30];
            end
            else if (busy_reg)
            begin
                if (!z_reg[lsc_pkg::ZW])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                if (step_reg == 5'(lsc_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                step_reg <= step_reg + 5'd1;
            end
        end
    end

    function automatic logic signed [17:0] rnd14(input logic signed [lsc_pkg::CW-1:0] v);
        logic signed [lsc_pkg::CW-1:0] a, r;
        begin
            a = v[lsc_pkg::CW-1] ? -v : v;
            r = (a + 33'sd8192) >>> 14;
            if (r > 33'sd65536)
                r = 33'sd65536;
            return v[lsc_pkg::CW-1] ? -18'(r) : 18'(r);
        end
    endfunction

    assign xr = x_reg;
    assign yr = y_reg;
    assign cv = rnd14(xr);
    assign sv = rnd14(yr);

    always_comb
    begin
        unique case (quad_reg)
            2'd0: begin result.c = cv;  result.s = sv;  end
            2'd1: begin result.c = -sv; result.s = cv;  end
            2'd2: begin result.c = -cv; result.s = -sv; end
            default: begin result.c = sv; result.s = -cv; end
        endcase
    end
endmodule

@@ hw/rtl/lsc_serial_mul.sv @@
// shift-add multiplier, one multiplier bit a cycle, then round >>16 half away from zero
module lsc_serial_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [19:0] a,
    input  logic signed [17:0] b,
    output logic               done,
    output logic signed [21:0] prod
);
    logic [19:0]        mag_a_reg;
    logic [16:0]        mag_b_reg;
    logic [36:0]        acc_reg;
    logic               neg_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic [36:0]        rnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                acc_reg   <= '0;
                mag_a_reg <= a[19] ? 20'(-a) : 20'(a);
                mag_b_reg <= b[17] ? 17'(-b) : 17'(b);
                neg_reg   <= a[19] ^ b[17];
            end
            else if (busy_reg)
            begin
                if (mag_b_reg[0])
                    acc_reg <= acc_reg + (37'(mag_a_reg) << cnt_reg);
                mag_b_reg <= mag_b_reg >> 1;
                cnt_reg   <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign rnd  = (acc_reg + 37'd32768) >> 16;
    assign prod = neg_reg ? -22'(rnd) : 22'(rnd);
endmodule

@@ hw/rtl/lidar_spherical_to_cartesian_filter_top.sv @@
// channel | direction | handshake           | payload
// in      | to block  | in_valid/in_ready   | range_mm azimuth elevation frame_last
// out     | from block| out_valid/out_ready | kept slot x_mm y_mm z_mm overflow frame_end point_count
// cfg     | to block  | cfg_valid/cfg_ready | cfg_index cfg_data
// one request at a time: a new request is taken only once the previous one is
// through, paced by the shared cordic (two 24-step passes) and the 17-step
// serial multiplier (four passes)
// reset clears slot counter and control, loads register defaults
// output register holds the result while out_ready is low; the next request
// is taken only once the previous result has left
module lidar_spherical_to_cartesian_filter_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [17:0]        range_mm,
    input  logic signed [15:0] azimuth,
    input  logic signed [15:0] elevation,
    input  logic               frame_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kept,
    output logic [14:0]        slot,
    output logic signed [18:0] x_mm,
    output logic signed [18:0] y_mm,
    output logic signed [18:0] z_mm,
    output logic               overflow,
    output logic               frame_end,
    output logic [15:0]        point_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [17:0]        cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_AZ, S_AZW, S_EL, S_ELW, S_RC, S_RCW, S_X, S_XW, S_Y, S_YW,
        S_Z, S_ZW, S_DEC, S_OUT
    } state_t;

    state_t              state_reg;
    logic [15:0]         tilt_reg;
    logic [17:0]         fwd_reg;
    logic [9:0]          zero_reg;
    logic [16:0]         next_slot_reg;
    logic [17:0]         r_reg;
    logic [15:0]         az_reg, el_reg;
    logic                last_reg;
    lsc_pkg::sincos_t    az_sc_reg, el_sc_reg;
    logic signed [19:0]  rc_reg;
    logic signed [21:0]  x_full_reg, y_full_reg, z_full_reg;

    logic                cor_start, cor_done;
    logic [31:0]         cor_phase;
    lsc_pkg::sincos_t    cor_res;
    logic                mul_start, mul_done;
    logic signed [19:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic signed [21:0]  mul_p;
    logic signed [18:0]  xs, ys, zs;
    logic                pass, room;

    lsc_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cor_start), .phase(cor_phase),
        .done(cor_done), .result(cor_res)
    );

    lsc_serial_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .prod(mul_p)
    );

    // elevation minus tilt wraps around the full turn
    assign cor_phase = (state_reg == S_AZ) ? {az_reg, 16'd0} : {el_reg - tilt_reg, 16'd0};
    assign cor_start = (state_reg == S_AZ) || (state_reg == S_EL);
    assign mul_start = (state_reg == S_RC) || (state_reg == S_X) ||
                       (state_reg == S_Y) || (state_reg == S_Z);

    always_comb
    begin
        unique case (state_reg)
            S_RC:    begin mul_a = 20'(signed'({2'b0, r_reg})); mul_b = el_sc_reg.c; end
            S_X:     begin mul_a = rc_reg; mul_b = az_sc_reg.c; end
            S_Y:     begin mul_a = rc_reg; mul_b = az_sc_reg.s; end
            default: begin mul_a = 20'(signed'({2'b0, r_reg})); mul_b = el_sc_reg.s; end
        endcase
    end

    function automatic logic signed [18:0] sat19(input logic signed [21:0] v);
        begin
            if (v > 22'sd262143)
                return 19'sd262143;
            else if (v < -22'sd262144)
                return -19'sd262144;
            return 19'(v);
        end
    endfunction

    function automatic logic [18:0] mag19(input logic signed [18:0] v);
        begin
            return v[18] ? 19'(-v) : 19'(v);
        end
    endfunction

    assign xs   = sat19(x_full_reg);
    assign ys   = sat19(y_full_reg);
    assign zs   = sat19(z_full_reg);
    assign pass = ((mag19(xs) > 19'(zero_reg)) || (mag19(ys) > 19'(zero_reg)) ||
                   (mag19(zs) > 19'(zero_reg))) &&
                  (xs[18] || (xs < 19'(signed'({1'b0, fwd_reg}))));
    assign room = next_slot_reg < 17'(lsc_pkg::MAX_POINTS);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tilt_reg      <= 16'd2549;
            fwd_reg       <= 18'd75000;
            zero_reg      <= 10'd1;
            next_slot_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                priority case (cfg_index)
                    lsc_pkg::REG_TILT: tilt_reg <= cfg_data[15:0];
                    lsc_pkg::REG_FWD:  fwd_reg  <= cfg_data;
                    lsc_pkg::REG_ZERO: zero_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        r_reg     <= range_mm;
                        az_reg    <= azimuth;
                        el_reg    <= elevation;
                        last_reg  <= frame_last;
                        state_reg <= S_AZ;
                    end
                end
                S_AZ:  state_reg <= S_AZW;
                S_AZW: if (cor_done) begin az_sc_reg <= cor_res; state_reg <= S_EL; end
                S_EL:  state_reg <= S_ELW;
                S_ELW: if (cor_done) begin el_sc_reg <= cor_res; state_reg <= S_RC; end
                S_RC:  state_reg <= S_RCW;
                S_RCW: if (mul_done) begin rc_reg <= 20'(mul_p); state_reg <= S_X; end
                S_X:   state_reg <= S_XW;
                S_XW:  if (mul_done) begin x_full_reg <= mul_p; state_reg <= S_Y; end
                S_Y:   state_reg <= S_YW;
                S_YW:  if (mul_done) begin y_full_reg <= mul_p; state_reg <= S_Z; end
                S_Z:   state_reg <= S_ZW;
                S_ZW:  if (mul_done) begin z_full_reg <= mul_p; state_reg <= S_DEC; end
                S_DEC:
                begin
                    kept        <= pass && room;
                    overflow    <= pass && !room;
                    slot        <= (pass && room) ? next_slot_reg[14:0] : 15'd0;
                    x_mm        <= xs;
                    y_mm        <= ys;
                    z_mm        <= zs;
                    frame_end   <= last_reg;
                    point_count <= (pass && room) ? 16'(next_slot_reg + 17'd1)
                                                  : next_slot_reg[15:0];
                    if (last_reg)
                        next_slot_reg <= '0;
                    else if (pass && room)
                        next_slot_reg <= next_slot_reg + 17'd1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/lsc_checker.sv @@
`include "lidar_spherical_to_cartesian_filter_top_macros.svh"
module lsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        kept,
    input logic        overflow,
    input logic [14:0] slot
);
    `LSC_ASSERT_IMPL(a_kept_ovf, clk, rst_n, out_valid, !(kept && overflow))
    `LSC_ASSERT_IMPL(a_slot_zero, clk, rst_n, out_valid && !kept, slot == 15'd0)
    `LSC_ASSERT_IMPL(a_one_at_a_time, clk, rst_n, out_valid, !in_ready)
    `LSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind lidar_spherical_to_cartesian_filter_top lsc_checker u_lsc_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .kept(kept),
    .overflow(overflow), .slot(slot)
);
